>>> rtl/grm_pkg.sv
// Shared types for the gradient/range mask block.
package grm_pkg;

  // Config register indexes on the cfg_ port.
  typedef enum logic [2:0] {
    CFG_GRAD_X  = 3'd0,
    CFG_GRAD_Y  = 3'd1,
    CFG_FLOOR   = 3'd2,
    CFG_CEILING = 3'd3,
    CFG_WIDTH   = 3'd4,
    CFG_HEIGHT  = 3'd5
  } cfg_reg_t;

  // Per-pixel position flags, computed when a pixel beat is taken.
  typedef struct packed {
    logic has_above;  // a row above exists, so its result is due now
    logic has_left;   // last row, not first column: left neighbor result is due
    logic last_col;
    logic last_row;
  } step_flags_t;

  // One result beat.
  typedef struct packed {
    logic [15:0] row;
    logic [11:0] col;
    logic        mask_bit;
    logic        frame_done;
  } result_t;

  localparam int unsigned SLOTS = 3;

endpackage

>>> rtl/grm_line_mem.sv
// Line store: one write port, two registered read ports.
module grm_line_mem #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 16,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd0_r;
  logic [DATA_W-1:0] rd1_r;

  // read-before-write on the same edge
  always_ff @(posedge clk) begin
    if (re) begin
      rd0_r <= mem[raddr0];
      rd1_r <= mem[raddr1];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata0 = rd0_r;
  assign rdata1 = rd1_r;

endmodule

>>> rtl/grm_emit.sv
// Mark evaluation, per-pixel result slots and the output register.
module grm_emit import grm_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         a_valid,
  output logic                         a_move,
  input  step_flags_t                  a_flags,
  input  logic [15:0]                  a_row,
  input  logic [11:0]                  a_col,
  input  logic signed [PIXEL_BITS-1:0] a_pixel,
  input  logic signed [PIXEL_BITS-1:0] a_prev,
  input  logic signed [PIXEL_BITS-1:0] above,
  input  logic signed [PIXEL_BITS-1:0] above_right,
  input  logic [15:0]                  grad_limit_x,
  input  logic [15:0]                  grad_limit_y,
  input  logic signed [15:0]           value_floor,
  input  logic signed [15:0]           value_ceiling,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_row,
  output logic [11:0]                  out_col,
  output logic                         out_mask_bit,
  output logic                         out_frame_done
);

  localparam int CMP_W = (PIXEL_BITS > 16) ? PIXEL_BITS : 16;

  function automatic logic [CMP_W-1:0] grad_mag(
    input logic signed [PIXEL_BITS-1:0] a,
    input logic signed [PIXEL_BITS-1:0] b
  );
    logic [PIXEL_BITS:0] d;
    logic [PIXEL_BITS:0] m;
    d = {a[PIXEL_BITS-1], a} - {b[PIXEL_BITS-1], b};
    m = d[PIXEL_BITS] ? (~d + 1'b1) : d;
    return CMP_W'(m[PIXEL_BITS-1:0]);
  endfunction

  function automatic logic out_of_range(input logic signed [PIXEL_BITS-1:0] v,
                                        input logic signed [15:0] lo,
                                        input logic signed [15:0] hi);
    logic signed [CMP_W-1:0] vx;
    logic signed [CMP_W-1:0] lx;
    logic signed [CMP_W-1:0] hx;
    vx = CMP_W'(v);
    lx = CMP_W'(lo);
    hx = CMP_W'(hi);
    return (vx < lx) || (vx > hx);
  endfunction

  result_t           slot_r [SLOTS];
  logic [SLOTS-1:0]  vld_r;
  result_t           out_r;
  logic              out_valid_r;

  logic [CMP_W-1:0]  lim_x;
  logic [CMP_W-1:0]  lim_y;
  logic              mk_up;
  logic              mk_left;
  logic              mk_self;
  logic              out_load;
  logic [SLOTS-1:0]  pick;
  logic              pop;
  logic              slots_free;
  result_t           pick_res;
  logic [SLOTS-1:0]  new_vld;

  assign lim_x = CMP_W'(grad_limit_x);
  assign lim_y = CMP_W'(grad_limit_y);

  // up: row above at this column; left: this row, column to the left
  assign mk_up   = (!a_flags.last_col && (grad_mag(above_right, above) > lim_x))
                || (grad_mag(a_pixel, above) > lim_y)
                || out_of_range(above, value_floor, value_ceiling);
  assign mk_left = (grad_mag(a_pixel, a_prev) > lim_x)
                || out_of_range(a_prev, value_floor, value_ceiling);
  assign mk_self = out_of_range(a_pixel, value_floor, value_ceiling);

  assign new_vld = {a_flags.last_row && a_flags.last_col, a_flags.has_left,
                    a_flags.has_above};

  assign out_load   = !out_valid_r || !out_stall;
  assign pick       = vld_r & (~vld_r + 1'b1);
  assign pop        = out_load && (vld_r != '0);
  // slots drain this cycle if empty or only one beat left and it leaves now
  assign slots_free = (vld_r == '0) || (pop && ((vld_r & (vld_r - 1'b1)) == '0));
  assign a_move     = a_valid && slots_free;

  always_comb begin
    pick_res = slot_r[0];
    if (pick[1]) pick_res = slot_r[1];
    if (pick[2]) pick_res = slot_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_move) begin
        vld_r <= new_vld;
      end else if (pop) begin
        vld_r <= vld_r & ~pick;
      end
      if (out_load) begin
        out_valid_r <= (vld_r != '0);
      end
    end
    if (a_move) begin
      slot_r[0] <= '{row: a_row - 16'd1, col: a_col, mask_bit: mk_up, frame_done: 1'b0};
      slot_r[1] <= '{row: a_row, col: a_col - 12'd1, mask_bit: mk_left, frame_done: 1'b0};
      slot_r[2] <= '{row: a_row, col: a_col, mask_bit: mk_self, frame_done: 1'b1};
    end
    if (pop) begin
      out_r <= pick_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = out_r.row;
  assign out_col        = out_r.col;
  assign out_mask_bit   = out_r.mask_bit;
  assign out_frame_done = out_r.frame_done;

endmodule

>>> rtl/gradient_range_mask.sv
// Gradient/range edge mask over a raster pixel stream, one line of delay.
// A result passes stage A, a result slot and the output register before it shows on out_*.
// Takes 1 pixel per cycle while out_stall is low, except on the last row, where a pixel
//   leaves up to three result slots that the single output register drains one at a time.
// Reset (rst_n low, synchronous): counters, previous pixel, valid flags and config
//   registers return to defaults; the line store is not cleared and needs no clearing pass.
module gradient_range_mask import grm_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_wdata,
  // pixel input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [PIXEL_BITS-1:0] in_pixel,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_row,
  output logic [11:0]                  out_col,
  output logic                         out_mask_bit,
  output logic                         out_frame_done
);

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int LIM_W = (COL_W + 1 > 13) ? COL_W + 1 : 13;

  // ---------------- configuration registers ----------------
  logic [15:0]        grad_x_r;
  logic [15:0]        grad_y_r;
  logic signed [15:0] floor_r;
  logic signed [15:0] ceil_r;
  logic [12:0]        width_r;
  logic [15:0]        height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_x_r <= 16'hFFFF;
      grad_y_r <= 16'hFFFF;
      floor_r  <= 16'sh8000;
      ceil_r   <= 16'sh7FFF;
      width_r  <= 13'd4096;
      height_r <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAD_X:  grad_x_r <= cfg_wdata;
        CFG_GRAD_Y:  grad_y_r <= cfg_wdata;
        CFG_FLOOR:   floor_r  <= $signed(cfg_wdata);
        CFG_CEILING: ceil_r   <= $signed(cfg_wdata);
        CFG_WIDTH:   width_r  <= cfg_wdata[12:0];
        CFG_HEIGHT:  height_r <= cfg_wdata;
        default: ;   // unused indexes are dropped
      endcase
    end
  end

  // ---------------- position tracking ----------------
  // Effective frame size: zero acts as one, width clamps to the line store depth.
  logic [COL_W-1:0]            col_r;
  logic [15:0]                 row_r;
  logic signed [PIXEL_BITS-1:0] prev_r;
  logic [LIM_W-1:0]            width_ext;
  logic [LIM_W-1:0]            width_eff;
  logic [15:0]                 height_eff;
  logic                        last_col;
  logic                        last_row;
  logic                        in_accept;
  step_flags_t                 flags;

  assign width_ext  = LIM_W'(width_r);
  assign width_eff  = (width_r == 13'd0) ? LIM_W'(1)
                    : (width_ext > LIM_W'(MAX_WIDTH)) ? LIM_W'(MAX_WIDTH) : width_ext;
  assign height_eff = (height_r == 16'd0) ? 16'd1 : height_r;

  // "at or beyond" compares keep counters sane if limits shrink mid-frame
  assign last_col = (LIM_W'(col_r) + LIM_W'(1)) >= width_eff;
  assign last_row = ({1'b0, row_r} + 17'd1) >= {1'b0, height_eff};

  assign flags = '{has_above: (row_r != 16'd0),
                   has_left:  last_row && (col_r != '0),
                   last_col:  last_col,
                   last_row:  last_row};

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      prev_r <= '0;
    end else if (in_accept) begin
      prev_r <= in_pixel;
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? 16'd0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // ---------------- line store ----------------
  // Each beat reads the row above at this column and the next one, and
  // overwrites this column with the new pixel. Reads see the old entry on
  // the same edge, and with a width of one the next beat's read of that entry
  // comes on a later edge than its write, so no forwarding is needed.
  logic [COL_W-1:0]      rd_addr1;
  logic [PIXEL_BITS-1:0] above_q;
  logic [PIXEL_BITS-1:0] above_right_q;

  assign rd_addr1 = last_col ? col_r : col_r + COL_W'(1);

  grm_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS),
    .ADDR_W (COL_W)
  ) u_line_mem (
    .clk    (clk),
    .we     (in_accept),
    .waddr  (col_r),
    .wdata  (in_pixel),
    .re     (in_accept),
    .raddr0 (col_r),
    .raddr1 (rd_addr1),
    .rdata0 (above_q),
    .rdata1 (above_right_q)
  );

  // ---------------- stage A: waits for line store data ----------------
  // Holds the beat until the result slots can take it; the read data
  // registers only load on accept, so they hold with it.
  logic                         a_valid_r;
  step_flags_t                  a_flags_r;
  logic [15:0]                  a_row_r;
  logic [11:0]                  a_col_r;
  logic signed [PIXEL_BITS-1:0] a_pixel_r;
  logic signed [PIXEL_BITS-1:0] a_prev_r;
  logic                         a_move;

  assign in_stall = a_valid_r && !a_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_accept || (a_valid_r && !a_move);
    end
    if (in_accept) begin
      a_flags_r <= flags;
      a_row_r   <= row_r;
      a_col_r   <= 12'(col_r);
      a_pixel_r <= in_pixel;
      a_prev_r  <= prev_r;
    end
  end

  // ---------------- stage B and output register ----------------
  grm_emit #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .a_valid        (a_valid_r),
    .a_move         (a_move),
    .a_flags        (a_flags_r),
    .a_row          (a_row_r),
    .a_col          (a_col_r),
    .a_pixel        (a_pixel_r),
    .a_prev         (a_prev_r),
    .above          ($signed(above_q)),
    .above_right    ($signed(above_right_q)),
    .grad_limit_x   (grad_x_r),
    .grad_limit_y   (grad_y_r),
    .value_floor    (floor_r),
    .value_ceiling  (ceil_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_mask_bit   (out_mask_bit),
    .out_frame_done (out_frame_done)
  );

endmodule
